@@ src/slt_pkg.sv @@
// shared types and constants for the sound level trigger
`default_nettype none

package slt_pkg;

    localparam int DATA_W  = 16;
    localparam int COUNT_W = 17;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIDPOINT  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_HOLDOFF   = 2'd2,
        REG_UNUSED    = 2'd3
    } cfg_reg_t;

    localparam logic [DATA_W-1:0] MIDPOINT_RST  = 16'd528;
    localparam logic [DATA_W-1:0] THRESHOLD_RST = 16'd150;
    localparam logic [DATA_W-1:0] HOLDOFF_RST   = 16'd1000;

    typedef struct packed {
        logic event_fire;
        logic holding;
    } det_t;

endpackage

`default_nettype wire

@@ src/sound_level_trigger.sv @@
// sound level trigger top level: config, ring pipeline and output register
//
// usage: one sample beat on in_valid/in_ready gives exactly one result beat
// on out_valid/out_ready carrying noise_event and in_holdoff.
// the ring read is issued when a sample is taken; the result is computed from
// the registered read and the running sum when the read stage advances, and
// lands in the output register, which drives out_valid.
// throughput is one sample per cycle while out_ready is high; the ring has
// one read and one write port and consecutive samples always touch different
// entries.
// while the receiver stalls the output register holds its beat and one more
// sample can wait in the read stage; in_ready drops only when both are full.
// config writes (cfg_we, cfg_index, cfg_data) are registered; index 3 is
// ignored. the threshold is kept as a precomputed sum limit.
// reset clears the ring (valid bits), write slot, running sum and holdoff
// state, and loads midpoint 528, threshold 150, holdoff 1000.
`default_nettype none

module sound_level_trigger
    import slt_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [DATA_W-1:0]    sample,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      noise_event,
    output logic                      in_holdoff
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = DATA_W + SLOT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [SUM_W-1:0]  WIN_S     = SUM_W'(WINDOW);
    localparam logic [SUM_W-1:0]  WIN_M1_S  = SUM_W'(WINDOW - 1);

    logic [DATA_W-1:0] midpoint_reg;
    logic [DATA_W-1:0] holdoff_reg;
    logic [SUM_W-1:0]  limit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_dev_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              out_valid_reg;
    logic              event_reg;
    logic              holdoff_reg_out;
    logic [DATA_W-1:0] dev;
    logic [DATA_W-1:0] old_dev;
    logic              accept;
    logic              advance;
    det_t              det;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;
    assign dev      = (sample >= midpoint_reg) ? (sample - midpoint_reg)
                                               : (midpoint_reg - sample);
    assign sum_next = sum_reg - SUM_W'(old_dev) + SUM_W'(s1_dev_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            midpoint_reg <= MIDPOINT_RST;
            holdoff_reg  <= HOLDOFF_RST;
            limit_reg    <= SUM_W'(THRESHOLD_RST) * WIN_S + WIN_M1_S;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIDPOINT:  midpoint_reg <= cfg_data;
                REG_THRESHOLD: limit_reg    <= SUM_W'(cfg_data) * WIN_S + WIN_M1_S;
                REG_HOLDOFF:   holdoff_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                sum_reg       <= sum_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept)
        begin
            s1_dev_reg  <= dev;
            s1_slot_reg <= slot_reg;
        end
        if (advance)
        begin
            event_reg       <= det.event_fire;
            holdoff_reg_out <= det.holding;
        end
    end

    slt_ring #(
        .WINDOW (WINDOW),
        .SLOT_W (SLOT_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_slot (slot_reg),
        .rd_data (old_dev),
        .wr_en   (advance),
        .wr_slot (s1_slot_reg),
        .wr_data (s1_dev_reg)
    );

    slt_detect #(
        .SUM_W (SUM_W)
    ) u_detect (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .sum_next      (sum_next),
        .limit         (limit_reg),
        .holdoff_ticks (holdoff_reg),
        .res           (det)
    );

    assign out_valid   = out_valid_reg;
    assign noise_event = event_reg;
    assign in_holdoff  = holdoff_reg_out;

    a_event_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && event_reg |-> holdoff_reg_out)
        else $error("event beat without holdoff");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        advance && out_valid_reg |-> out_ready)
        else $error("output register overwritten");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(slot_reg) < WIN_S)
        else $error("write slot out of range");

endmodule

`default_nettype wire

@@ src/slt_ring.sv @@
// deviation ring memory with per-entry valid bits and registered read
`default_nettype none

module slt_ring
    import slt_pkg::*;
#(
    parameter int WINDOW = 8,
    parameter int SLOT_W = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [SLOT_W-1:0] rd_slot,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_slot,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [WINDOW];
    logic [WINDOW-1:0] valid_reg;
    logic [DATA_W-1:0] rd_mem_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_slot];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

`default_nettype wire

@@ src/slt_detect.sv @@
// holdoff counter and mean threshold check
`default_nettype none

module slt_detect
    import slt_pkg::*;
#(
    parameter int SUM_W = 19
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [SUM_W-1:0]   sum_next,
    input  wire logic [SUM_W-1:0]   limit,
    input  wire logic [DATA_W-1:0]  holdoff_ticks,
    output det_t                    res
);

    logic               holding_reg;
    logic               holding_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               hold_mid;

    always_comb
    begin
        count_inc    = count_reg + COUNT_W'(1);
        hold_mid     = holding_reg;
        count_next   = count_reg;
        res          = '0;
        if (holding_reg)
        begin
            count_next = count_inc;
            if (count_inc > COUNT_W'(holdoff_ticks))
            begin
                hold_mid   = 1'b0;
                count_next = '0;
            end
        end
        if (!hold_mid && (sum_next > limit))
        begin
            res.event_fire = 1'b1;
            hold_mid       = 1'b1;
        end
        res.holding  = hold_mid;
        holding_next = hold_mid;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            holding_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            holding_reg <= holding_next;
            count_reg   <= count_next;
        end
    end

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !holding_reg |-> count_reg == '0)
        else $error("holdoff count nonzero outside holdoff");

    a_rise_on_event: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(holding_reg) |-> $past(step) && $past(res.event_fire))
        else $error("holdoff entered without an event");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(65536))
        else $error("holdoff count out of range");

    a_hold_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(step) |-> $stable(holding_reg) && $stable(count_reg))
        else $error("holdoff state moved without a beat");

endmodule

`default_nettype wire
